>>> rtl/cksa_pkg.sv
// Shared constants and types for the checked signed ALU.
`default_nettype none
package cksa_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int PORT_WIDTH     = 64;

    // operation selector
    localparam logic [1:0] K_ADD = 2'd0;
    localparam logic [1:0] K_SUB = 2'd1;
    localparam logic [1:0] K_MUL = 2'd2;
    localparam logic [1:0] K_DIV = 2'd3;

    // result status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // divider side flags, travel with the quotient
    typedef struct packed {
        logic divz;
        logic ovf;
        logic neg;
    } cksa_dflag_t;

endpackage
`default_nettype wire

>>> rtl/cksa_mul.sv
// Pipelined signed multiplier with overflow check and combinational output logic.
`default_nettype none
module cksa_mul #(
    parameter int W = cksa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W-1:0] val,
    output logic              ovf
);
    localparam int H = (W + 1) / 2;
    localparam int F = 2 * H;

    logic [W-1:0]   ma_reg, mb_reg;
    logic           sg0_reg, sg1_reg, sg2_reg;
    logic [F-1:0]   mae, mbe;
    logic [F-1:0]   pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic [2*F-1:0] prod_reg;
    logic [W-1:0]   lo, limit;
    logic           hi_nz, neg;

    assign mae = F'(ma_reg);
    assign mbe = F'(mb_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= a[W-1] ? (W'(0) - a) : a;
            mb_reg   <= b[W-1] ? (W'(0) - b) : b;
            sg0_reg  <= a[W-1] ^ b[W-1];
            // four half-width partial products
            pp0_reg  <= mae[H-1:0] * mbe[H-1:0];
            pp1_reg  <= mae[H-1:0] * mbe[F-1:H];
            pp2_reg  <= mae[F-1:H] * mbe[H-1:0];
            pp3_reg  <= mae[F-1:H] * mbe[F-1:H];
            sg1_reg  <= sg0_reg;
            prod_reg <= {pp3_reg, pp0_reg}
                      + ((2*F)'({1'b0, pp1_reg} + {1'b0, pp2_reg}) << H);
            sg2_reg  <= sg1_reg;
        end
    end

    assign lo    = prod_reg[W-1:0];
    assign hi_nz = |prod_reg[2*F-1:W];
    assign neg   = sg2_reg && (|lo);
    assign limit = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign ovf   = hi_nz || (lo > limit);
    assign val   = neg ? (W'(0) - lo) : lo;

endmodule
`default_nettype wire

>>> rtl/cksa_div.sv
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module cksa_div #(
    parameter int W = cksa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [W-1:0]       a,
    input  wire logic [W-1:0]       b,
    output logic      [W-1:0]       quo,
    output cksa_pkg::cksa_dflag_t   flags
);
    logic [W-1:0]          rem_reg [0:W];
    logic [W-1:0]          num_reg [0:W];
    logic [W-1:0]          den_reg [0:W];
    cksa_pkg::cksa_dflag_t flg_reg [0:W];
    logic [W:0]            shf     [1:W];
    logic [W:0]            trial   [1:W];

    always_comb
    begin
        for (int i = 1; i <= W; i++)
        begin
            shf[i]   = {rem_reg[i-1], num_reg[i-1][W-1]};
            trial[i] = shf[i] - {1'b0, den_reg[i-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 0: magnitudes and special cases
            rem_reg[0]    <= '0;
            num_reg[0]    <= a[W-1] ? (W'(0) - a) : a;
            den_reg[0]    <= b[W-1] ? (W'(0) - b) : b;
            flg_reg[0].divz <= (b == '0);
            flg_reg[0].ovf  <= (a == {1'b1, {(W-1){1'b0}}}) && (&b);
            flg_reg[0].neg  <= a[W-1] ^ b[W-1];
            for (int i = 1; i <= W; i++)
            begin
                if (!trial[i][W])
                begin
                    rem_reg[i] <= trial[i][W-1:0];
                end
                else
                begin
                    rem_reg[i] <= shf[i][W-1:0];
                end
                num_reg[i] <= {num_reg[i-1][W-2:0], ~trial[i][W]};
                den_reg[i] <= den_reg[i-1];
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    assign quo   = num_reg[W];
    assign flags = flg_reg[W];

endmodule
`default_nettype wire

>>> rtl/checked_signed_alu.sv
// Top level: overflow-checked signed ALU (add, subtract, multiply, divide).
// Path from accepted word to result word: input register, side line alongside the
// divider (which resolves one quotient bit per stage), then output register.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and not taken. Reset (rst_n low) clears all valid bits.
`default_nettype none
module checked_signed_alu #(
    parameter int DATA_WIDTH = cksa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // operand_a [63:0], operand_b [127:64]
    input  wire logic [1:0]   s_tuser,   // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata    // value [63:0], status [65:64], zero pad
);
    localparam int W = DATA_WIDTH;
    localparam int PW = cksa_pkg::PORT_WIDTH;
    localparam int MUL_TAP = 3;   // side-line stage where the multiplier result lands

    // global advance: everything moves when the output slot frees up
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: input register, operands cut to W bits
    logic         p_valid_reg;
    logic [1:0]   p_kind_reg;
    logic [W-1:0] p_a_reg, p_b_reg;

    // side line: kind and add/sub/mul result travel alongside the divider
    logic         sd_valid_reg [0:W];
    logic [1:0]   sd_kind_reg  [0:W];
    logic [W-1:0] sd_val_reg   [0:W];
    logic [1:0]   sd_st_reg    [0:W];

    // add / subtract in the first side stage
    logic [W-1:0] sum;
    logic         is_sub, add_ovf;
    assign is_sub  = (p_kind_reg == cksa_pkg::K_SUB);
    assign sum     = is_sub ? (p_a_reg - p_b_reg) : (p_a_reg + p_b_reg);
    assign add_ovf = is_sub
        ? ((p_a_reg[W-1] != p_b_reg[W-1]) && (sum[W-1] != p_a_reg[W-1]))
        : ((p_a_reg[W-1] == p_b_reg[W-1]) && (sum[W-1] != p_a_reg[W-1]));

    logic [W-1:0]          mul_val;
    logic                  mul_ovf;
    logic [W-1:0]          div_quo;
    cksa_pkg::cksa_dflag_t div_flags;

    cksa_mul #(.W(W)) u_mul (
        .clk (clk),
        .en  (adv),
        .a   (p_a_reg),
        .b   (p_b_reg),
        .val (mul_val),
        .ovf (mul_ovf)
    );

    cksa_div #(.W(W)) u_div (
        .clk   (clk),
        .en    (adv),
        .a     (p_a_reg),
        .b     (p_b_reg),
        .quo   (div_quo),
        .flags (div_flags)
    );

    // final select
    logic [W-1:0] fin_val;
    logic [1:0]   fin_st;
    always_comb
    begin
        fin_val = sd_val_reg[W];
        fin_st  = sd_st_reg[W];
        if (sd_kind_reg[W] == cksa_pkg::K_DIV)
        begin
            if (div_flags.divz)
            begin
                fin_val = '0;
                fin_st  = cksa_pkg::ST_DIVZ;
            end
            else if (div_flags.ovf)
            begin
                fin_val = '0;
                fin_st  = cksa_pkg::ST_OVF;
            end
            else
            begin
                fin_val = div_flags.neg ? (W'(0) - div_quo) : div_quo;
                fin_st  = cksa_pkg::ST_OK;
            end
        end
    end

    logic         out_valid_reg;
    logic [W-1:0] out_val_reg;
    logic [1:0]   out_st_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= W; i++)
            begin
                sd_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            p_valid_reg     <= s_tvalid;
            sd_valid_reg[0] <= p_valid_reg;
            for (int i = 1; i <= W; i++)
            begin
                sd_valid_reg[i] <= sd_valid_reg[i-1];
            end
            out_valid_reg <= sd_valid_reg[W];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_kind_reg <= s_tuser;
            p_a_reg    <= s_tdata[W-1:0];
            p_b_reg    <= s_tdata[PW+W-1:PW];

            sd_kind_reg[0] <= p_kind_reg;
            sd_val_reg[0]  <= add_ovf ? '0 : sum;
            sd_st_reg[0]   <= add_ovf ? cksa_pkg::ST_OVF : cksa_pkg::ST_OK;
            for (int i = 1; i <= W; i++)
            begin
                sd_kind_reg[i] <= sd_kind_reg[i-1];
                if ((i == MUL_TAP) && (sd_kind_reg[i-1] == cksa_pkg::K_MUL))
                begin
                    sd_val_reg[i] <= mul_ovf ? '0 : mul_val;
                    sd_st_reg[i]  <= mul_ovf ? cksa_pkg::ST_OVF : cksa_pkg::ST_OK;
                end
                else
                begin
                    sd_val_reg[i] <= sd_val_reg[i-1];
                    sd_st_reg[i]  <= sd_st_reg[i-1];
                end
            end

            out_val_reg <= fin_val;
            out_st_reg  <= fin_st;
        end
    end

    // value sign-extended from W bits to the port width
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_st_reg, PW'($signed(out_val_reg))};

endmodule
`default_nettype wire

>>> tb/tb_checked_signed_alu.sv
// Testbench for the checked signed ALU: directed corners, then random words against a predictor.
`timescale 1ns / 100ps
`default_nettype none

module tb_checked_signed_alu;

    localparam int DW        = 64;
    localparam int LATENCY   = DW + 3;
    localparam int N_RANDOM  = 400;
    localparam int LIMIT_CYC = 200000;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINUS1   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } alu_res_t;

    // Word predictor plus queue of expected results.
    class alu_scoreboard;
        alu_res_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        // Exact arithmetic in 130-bit signed space, then range checks.
        function alu_res_t compute(logic [1:0] kind, logic [63:0] a, logic [63:0] b);
            alu_res_t      r;
            logic signed [129:0] sa, sb, wide, q;
            logic signed [129:0] lo_lim, hi_lim;
            sa = {{66{a[63]}}, a};
            sb = {{66{b[63]}}, b};
            lo_lim = {{66{1'b1}}, MOST_NEG};
            hi_lim = {66'd0, MOST_POS};
            r.value  = '0;
            r.status = cksa_pkg::ST_OK;
            case (kind)
                cksa_pkg::K_ADD: wide = sa + sb;
                cksa_pkg::K_SUB: wide = sa - sb;
                cksa_pkg::K_MUL: wide = sa * sb;
                default:
                begin
                    if (b == 64'd0)
                    begin
                        r.status = cksa_pkg::ST_DIVZ;
                        return r;
                    end
                    q = sa / sb; // truncates toward zero
                    wide = q;
                end
            endcase
            if (wide < lo_lim || wide > hi_lim)
                r.status = cksa_pkg::ST_OVF;
            else
                r.value = wide[63:0];
            return r;
        endfunction

        function void note_input(logic [1:0] kind, logic [63:0] a, logic [63:0] b);
            pending.push_back(compute(kind, a, b));
        endfunction

        task check_result(logic [71:0] word);
            alu_res_t exp_r;
            if (pending.size() == 0)
            begin
                report($sformatf("result word %h with nothing pending", word));
                return;
            end
            exp_r = pending.pop_front();
            if (word[63:0] !== exp_r.value)
                report($sformatf("value %h, predicted %h", word[63:0], exp_r.value));
            if (word[65:64] !== exp_r.status)
                report($sformatf("status %0d, predicted %0d", word[65:64], exp_r.status));
            if (word[71:66] !== 6'd0)
                report($sformatf("pad bits %b not zero", word[71:66]));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // operand_a [63:0], operand_b [127:64]
    logic [1:0]   s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;   // value [63:0], status [65:64], zero pad

    alu_scoreboard sb;
    bit            hold_sink;  // long receiver hold-off to back up the pipe
    int            cycle_cnt = 0;

    checked_signed_alu #(.DATA_WIDTH(DW)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap per word: mostly zero so back-to-back stretches happen.
    function int draw_gap();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
    endfunction

    function logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operand biased toward corners and small magnitudes.
    function logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS1;
            3: return 64'd0;
            4: return {{32{1'b0}}, $urandom()};       // fits half width
            5: return {{32{1'b1}}, $urandom()};
            6: return $signed($urandom_range(0, 40)) - 20;
            default: return rand64();
        endcase
    endfunction

    // valid stays high across words sent back to back
    task automatic send_word(logic [1:0] kind, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(kind, a, b);
    endtask

    // Receiver: random waits per word; ready follows the hold-off flag.
    initial
    begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = draw_gap();
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            do
            begin
                m_tready <= !hold_sink;
                @(posedge clk);
            end
            while (!(m_tvalid && m_tready));
            sb.check_result(m_tdata);
        end
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYC)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] dir_a[$];
        logic [63:0] dir_b[$];
        int tail;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = cksa_pkg::K_ADD;
        hold_sink = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation over the corner pairs.
        dir_a = '{MOST_NEG, MOST_POS, MINUS1, 64'd0, 64'd7};
        dir_b = '{MINUS1, 64'd1, 64'd0, MOST_NEG, 64'hFFFF_FFFF_FFFF_FFFE};
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < dir_a.size(); i++)
                send_word(k[1:0], dir_a[i], dir_b[i]);
        send_word(cksa_pkg::K_MUL, 64'h0000_0001_0000_0000,
                  64'hFFFF_FFFF_8000_0000);                        // exactly most negative
        send_word(cksa_pkg::K_MUL, 64'h0000_0001_0000_0000,
                  64'h0000_0000_8000_0000);                        // just over
        send_word(cksa_pkg::K_MUL, 64'd0, MOST_NEG);               // zero product
        send_word(cksa_pkg::K_DIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2); // -7/2 toward zero

        // Pressure phase: receiver holds off while sender keeps offering.
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge clk);
                hold_sink = 1'b0;
            end
            begin
                for (int i = 0; i < 120; i++)
                    send_word(2'($urandom()), pick_operand(), pick_operand());
            end
        join

        for (int i = 0; i < N_RANDOM - 120; i++)
            send_word(2'($urandom()), pick_operand(), pick_operand());
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        tail = 0;
        while (tail < 2 * LATENCY)
        begin
            @(posedge clk);
            tail++;
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
